// ===== hdl/rtufc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtufc_pkg
// Shared types, constants and the CRC-16 byte update for the RTU frame
// checker and exception responder.
// ----------------------------------------------------------------------------
package rtufc_pkg;

  // Frame limits
  localparam int MAX_FRAME_LEN = 256;
  localparam int COUNT_W       = $clog2(MAX_FRAME_LEN + 1);
  localparam int MIN_FRAME_LEN = 5;
  localparam int REQ_FRAME_LEN = 8;
  localparam int NUM_FUNCTIONS = 6;
  localparam int PAYLOAD_HEAD  = 4;

  // CRC-16, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Exception frame contents
  localparam logic [7:0] EXC_FN_FLAG      = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'h01;

  // Result kinds
  localparam logic KIND_REQUEST   = 1'b0;
  localparam logic KIND_EXCEPTION = 1'b1;

  // Command queue between front and back
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int CMD_PTR_W       = $clog2(CMD_QUEUE_DEPTH);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_STATION_ADDRESS      = 1'b0,
    REG_FUNCTION_ENABLE_MASK = 1'b1
  } cfg_reg_t;

  // Input item
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic        out_kind;
    logic [7:0]  req_function;
    logic [15:0] req_address;
    logic [15:0] req_operand;
    logic [7:0]  tx_byte;
    logic        tx_last;
  } result_t;

  // Classified frame handed from front to back
  typedef struct packed {
    logic        is_exception;
    logic [7:0]  station;
    logic [7:0]  func;
    logic [15:0] address;
    logic [15:0] operand;
  } cmd_t;

  // One byte of the reflected CRC-16 update
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rtufc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtufc_front
// Receive side: runs the CRC over each byte, tracks length, function code
// and the first four payload bytes, and classifies the frame on its last byte.
// ----------------------------------------------------------------------------
module rtufc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire rtufc_pkg::in_item_t item,
  input  wire logic [7:0]        station_address,
  input  wire logic [5:0]        function_enable_mask,
  output logic                   cmd_push,
  output rtufc_pkg::cmd_t        cmd
);

  logic [15:0]                   running_crc;
  logic [rtufc_pkg::COUNT_W-1:0] byte_count;
  logic [7:0]                    held_function;
  logic                          overrun_flag;
  logic [7:0]                    payload_head [rtufc_pkg::PAYLOAD_HEAD];

  logic [15:0]                   crc_next;
  logic [rtufc_pkg::COUNT_W-1:0] count_next;
  logic                          overrun_next;
  logic                          at_max;
  logic                          frame_ok;
  logic                          fn_in_range;
  logic                          fn_enabled;
  logic [2:0]                    fn_idx;
  logic [7:0]                    mask_ext;
  logic [1:0]                    head_idx;
  logic                          head_wr;

  // Per-byte bookkeeping
  always_comb begin
    at_max       = (byte_count == rtufc_pkg::COUNT_W'(rtufc_pkg::MAX_FRAME_LEN));
    count_next   = at_max ? byte_count : byte_count + 1'b1;
    overrun_next = overrun_flag | at_max;
    crc_next     = rtufc_pkg::crc_byte(running_crc, item.rx_byte);
    head_idx     = byte_count[1:0] - 2'd2;
    head_wr      = !at_max && (byte_count >= rtufc_pkg::COUNT_W'(2)) &&
                   (byte_count <= rtufc_pkg::COUNT_W'(5));
  end

  // Frame classification on the last byte
  always_comb begin
    fn_in_range = (held_function >= 8'd1) &&
                  (held_function <= 8'(rtufc_pkg::NUM_FUNCTIONS));
    fn_idx      = held_function[2:0] - 3'd1;
    mask_ext    = {2'b00, function_enable_mask};
    fn_enabled  = fn_in_range && mask_ext[fn_idx];
    frame_ok    = !overrun_next &&
                  (count_next >= rtufc_pkg::COUNT_W'(rtufc_pkg::MIN_FRAME_LEN)) &&
                  (crc_next == 16'h0000);
    cmd_push    = accept && item.last_byte && frame_ok &&
                  (!fn_enabled ||
                   (count_next == rtufc_pkg::COUNT_W'(rtufc_pkg::REQ_FRAME_LEN)));

    cmd.is_exception = !fn_enabled;
    cmd.station      = station_address;
    cmd.func         = held_function;
    cmd.address      = {payload_head[0], payload_head[1]};
    cmd.operand      = {payload_head[2], payload_head[3]};
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc   <= rtufc_pkg::CRC_INIT;
      byte_count    <= '0;
      overrun_flag  <= 1'b0;
      held_function <= 8'h00;
    end else if (accept) begin
      if (!at_max && byte_count == rtufc_pkg::COUNT_W'(1)) begin
        held_function <= item.rx_byte;
      end
      if (item.last_byte) begin
        running_crc  <= rtufc_pkg::CRC_INIT;
        byte_count   <= '0;
        overrun_flag <= 1'b0;
      end else begin
        running_crc  <= crc_next;
        byte_count   <= count_next;
        overrun_flag <= overrun_next;
      end
    end
  end

  // Payload head store, written before it is read
  always_ff @(posedge clk) begin
    if (accept && head_wr) begin
      payload_head[head_idx] <= item.rx_byte;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rtufc_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtufc_cmd_fifo
// Short command queue that decouples frame classification from response
// generation.
// ----------------------------------------------------------------------------
module rtufc_cmd_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rtufc_pkg::cmd_t wdata,
  output logic                 full,
  input  wire logic            pop,
  output rtufc_pkg::cmd_t      rdata,
  output logic                 empty
);

  localparam int CntW = $clog2(rtufc_pkg::CMD_QUEUE_DEPTH + 1);

  rtufc_pkg::cmd_t                 entries [rtufc_pkg::CMD_QUEUE_DEPTH];
  logic [rtufc_pkg::CMD_PTR_W-1:0] wptr;
  logic [rtufc_pkg::CMD_PTR_W-1:0] rptr;
  logic [CntW-1:0]                 count;
  logic                            do_push;
  logic                            do_pop;

  always_comb begin
    full    = (count == CntW'(rtufc_pkg::CMD_QUEUE_DEPTH));
    empty   = (count == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    rdata   = entries[rptr];
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rtufc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtufc_back
// Response side: turns each command into one request result or a five-byte
// exception frame with its CRC, and buffers results in a two-entry queue.
// ----------------------------------------------------------------------------
module rtufc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  input  wire rtufc_pkg::cmd_t cmd,
  output logic                 cmd_pop,
  input  wire logic            pop,
  output logic                 empty,
  output rtufc_pkg::result_t   result
);

  // Exception byte sequencer
  typedef enum logic [4:0] {
    EXC_ADDR  = 5'b00001,
    EXC_FUNC  = 5'b00010,
    EXC_CODE  = 5'b00100,
    EXC_CRC_L = 5'b01000,
    EXC_CRC_H = 5'b10000
  } exc_step_t;

  exc_step_t           step;
  exc_step_t           step_next;
  logic [15:0]         crc;
  logic [15:0]         crc_seed;
  logic [15:0]         crc_next;
  logic                emit;
  rtufc_pkg::result_t  item;

  rtufc_pkg::result_t  outq [2];
  logic                out_wptr;
  logic                out_rptr;
  logic [1:0]          out_count;
  logic                out_space;
  logic                out_pop;

  // Build the next result item
  always_comb begin
    out_space = (out_count != 2'd2);
    emit      = cmd_valid && out_space;
    item      = '0;
    step_next = step;
    cmd_pop   = 1'b0;
    if (!cmd.is_exception) begin
      item.out_kind     = rtufc_pkg::KIND_REQUEST;
      item.req_function = cmd.func;
      item.req_address  = cmd.address;
      item.req_operand  = cmd.operand;
      cmd_pop           = emit;
    end else begin
      item.out_kind = rtufc_pkg::KIND_EXCEPTION;
      unique case (step)
        EXC_ADDR: begin
          item.tx_byte = cmd.station;
          step_next    = EXC_FUNC;
        end
        EXC_FUNC: begin
          item.tx_byte = cmd.func + rtufc_pkg::EXC_FN_FLAG;
          step_next    = EXC_CODE;
        end
        EXC_CODE: begin
          item.tx_byte = rtufc_pkg::EXC_ILLEGAL_FUNC;
          step_next    = EXC_CRC_L;
        end
        EXC_CRC_L: begin
          item.tx_byte = crc[7:0];
          step_next    = EXC_CRC_H;
        end
        EXC_CRC_H: begin
          item.tx_byte = crc[15:8];
          item.tx_last = 1'b1;
          step_next    = EXC_ADDR;
          cmd_pop      = emit;
        end
        default: begin
          step_next = EXC_ADDR;
        end
      endcase
    end
    crc_seed = (step == EXC_ADDR) ? rtufc_pkg::CRC_INIT : crc;
    crc_next = rtufc_pkg::crc_byte(crc_seed, item.tx_byte);
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= EXC_ADDR;
    end else if (emit && cmd.is_exception) begin
      step <= step_next;
    end
  end

  // CRC over the three exception header bytes only; held while the CRC bytes go out
  always_ff @(posedge clk) begin
    if (emit && cmd.is_exception &&
        (step == EXC_ADDR || step == EXC_FUNC || step == EXC_CODE)) begin
      crc <= crc_next;
    end
  end

  // Result queue control
  always_comb begin
    empty   = (out_count == 2'd0);
    out_pop = pop && !empty;
    result  = outq[out_rptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wptr  <= 1'b0;
      out_rptr  <= 1'b0;
      out_count <= 2'd0;
    end else begin
      if (emit)    out_wptr <= ~out_wptr;
      if (out_pop) out_rptr <= ~out_rptr;
      if (emit && !out_pop)      out_count <= out_count + 2'd1;
      else if (!emit && out_pop) out_count <= out_count - 2'd1;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (emit) begin
      outq[out_wptr] <= item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rtu_frame_checker_responder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtu_frame_checker_responder_core
// RTU frame checker with CRC-16 and exception responder.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle while full is low; the byte-wide CRC
// update sets it. A frame's first result is registered in the command queue and
// then the result queue. Exception frames leave at one byte per cycle while the
// result queue has room; full rises only while the two-entry command queue is
// occupied. Reset (rst, synchronous) clears the frame state, both queues, and
// loads station_address = 1 and function_enable_mask = 0. No clearing pass.
// ----------------------------------------------------------------------------
module rtu_frame_checker_responder_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input queue side
  input  wire logic                  push,
  output logic                       full,
  input  wire rtufc_pkg::in_item_t   rx_item,
  // result queue side
  output logic                       empty,
  input  wire logic                  pop,
  output rtufc_pkg::result_t         result,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire rtufc_pkg::cfg_reg_t   cfg_index,
  input  wire logic [7:0]            cfg_data
);

  logic [7:0]      station_address;
  logic [5:0]      function_enable_mask;
  logic            accept;
  logic            cmd_push;
  logic            cmd_full;
  logic            cmd_empty;
  logic            cmd_pop;
  rtufc_pkg::cmd_t cmd_in;
  rtufc_pkg::cmd_t cmd_out;

  assign cfg_ready = 1'b1;
  assign full      = cmd_full;
  assign accept    = push && !full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      station_address      <= 8'h01;
      function_enable_mask <= 6'h00;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rtufc_pkg::REG_STATION_ADDRESS:      station_address      <= cfg_data;
        rtufc_pkg::REG_FUNCTION_ENABLE_MASK: function_enable_mask <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  rtufc_front u_front (
    .clk                  (clk),
    .rst                  (rst),
    .accept               (accept),
    .item                 (rx_item),
    .station_address      (station_address),
    .function_enable_mask (function_enable_mask),
    .cmd_push             (cmd_push),
    .cmd                  (cmd_in)
  );

  rtufc_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  rtufc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  // A command is only produced when the queue has room for it
  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command pushed into a full queue");

  // Only the last byte of a frame can produce a command
  a_cmd_on_last_only: assert property (@(posedge clk) disable iff (rst)
    (accept && !rx_item.last_byte) |-> !cmd_push)
    else $error("command produced before the end of a frame");

  // The final-byte mark belongs to exception frames only
  a_tx_last_kind: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.tx_last) |-> (result.out_kind == rtufc_pkg::KIND_EXCEPTION))
    else $error("tx_last set on a request result");

endmodule
`default_nettype wire
